// ===== design/pptev_pkg.sv =====
// Shared constants, types and coefficient tables of the trajectory evaluator.
`default_nettype none
package pptev_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int NUM_AXES         = 3;
  localparam int NUM_COEF         = 8;
  localparam int COEF_W           = 64;
  localparam int TIME_W           = 24;
  localparam int OUT_W            = 32;
  localparam int MULT_W           = 7;
  localparam int IN_DATA_W        = 104;
  localparam int OUT_DATA_W       = 296;

  // request kinds on in_tuser
  localparam logic [1:0] REQ_WR_START = 2'd0;
  localparam logic [1:0] REQ_WR_COEF  = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;
  localparam logic [1:0] REQ_RSVD     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SEG_COUNT = 3'd0;
  localparam logic [2:0] REG_TOTAL_DUR = 3'd1;
  localparam logic [2:0] REG_END_X     = 3'd2;
  localparam logic [2:0] REG_END_Y     = 3'd3;
  localparam logic [2:0] REG_END_Z     = 3'd4;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    DRV_POS = 2'd0,
    DRV_VEL = 2'd1,
    DRV_ACC = 2'd2
  } drv_kind_t;

  // per-step control of one Horner unit
  typedef struct packed {
    logic clr;
    logic sc;
    logic p2;
    logic rnd;
    logic add;
    logic first;
    logic active;
  } horner_ctl_t;

  // derivative factor applied to coefficient slot j
  function automatic logic [MULT_W-1:0] deriv_mult(input drv_kind_t kind,
                                                   input logic [2:0] j);
    logic [MULT_W-1:0] m;
    m = '0;
    case (kind)
      DRV_POS: m = 7'd1;
      DRV_VEL: m = 7'(4'd7 - {1'b0, j});
      DRV_ACC: begin
        case (j)
          3'd0:    m = 7'd42;
          3'd1:    m = 7'd30;
          3'd2:    m = 7'd20;
          3'd3:    m = 7'd12;
          3'd4:    m = 7'd6;
          3'd5:    m = 7'd2;
          default: m = 7'd0;
        endcase
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  // number of Horner terms per derivative
  function automatic logic [3:0] deriv_terms(input drv_kind_t kind);
    logic [3:0] n;
    n = 4'd8;
    case (kind)
      DRV_POS: n = 4'd8;
      DRV_VEL: n = 4'd7;
      DRV_ACC: n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/pptev_store.sv =====
// Coefficient and segment start memories, registered read ports.
`default_nettype none
module pptev_store #(
  parameter int MAX_SEGMENTS = pptev_pkg::MAX_SEGMENTS_DEF,
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int CDEPTH = MAX_SEGMENTS * pptev_pkg::NUM_AXES * pptev_pkg::NUM_COEF,
  localparam int AW = $clog2(CDEPTH)
) (
  input  wire                                   clk,
  input  wire                                   start_we,
  input  wire  [IW-1:0]                         start_waddr,
  input  wire  [pptev_pkg::TIME_W-1:0]          start_wdata,
  input  wire  [IW-1:0]                         start_raddr,
  output logic [pptev_pkg::TIME_W-1:0]          start_rdata,
  input  wire                                   coef_we,
  input  wire  [AW-1:0]                         coef_waddr,
  input  wire  [pptev_pkg::COEF_W-1:0]          coef_wdata,
  input  wire  [AW-1:0]                         coef_raddr,
  output logic signed [pptev_pkg::COEF_W-1:0]   coef_rdata
);

  logic [pptev_pkg::TIME_W-1:0] start_mem [MAX_SEGMENTS];
  logic [pptev_pkg::COEF_W-1:0] coef_mem  [CDEPTH];

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    start_rdata <= start_mem[start_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= $signed(coef_mem[coef_raddr]);
  end

endmodule
`default_nettype wire

// ===== design/pptev_horner.sv =====
// One saturating Horner accumulator with a 64x24 time multiply split into low and high partial products.
`default_nettype none
module pptev_horner (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  pptev_pkg::horner_ctl_t         ctl,
  input  wire  [pptev_pkg::MULT_W-1:0]         k,
  input  wire  signed [pptev_pkg::COEF_W-1:0]  coef,
  input  wire  [pptev_pkg::TIME_W-1:0]         t,
  output logic signed [pptev_pkg::COEF_W-1:0]  acc_o,
  output logic                                 clip_o
);

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  logic signed [63:0] cs_r, p_r, acc_r;
  logic        [55:0] pl_r;
  logic signed [56:0] ph_r;
  logic               clip_r;

  logic signed [71:0] sc_full;
  logic               sc_ovf;
  logic signed [63:0] cs_nxt;
  logic        [55:0] pl_nxt;
  logic signed [56:0] ph_nxt;
  logic signed [88:0] full;
  logic               p_ovf;
  logic signed [63:0] p_nxt;
  logic signed [64:0] sum;
  logic               add_ovf;
  logic signed [63:0] acc_nxt;
  logic               clip_nxt;

  always_comb begin
    sc_full = coef * $signed({1'b0, k});
    sc_ovf  = (sc_full[71:63] != {9{sc_full[63]}});
    cs_nxt  = sc_ovf ? (sc_full[71] ? SMIN : SMAX) : sc_full[63:0];
    pl_nxt  = acc_r[31:0] * t;
    ph_nxt  = $signed(acc_r[63:32]) * $signed({1'b0, t});
    // rounded product, ties toward plus infinity
    full    = (89'(ph_r) <<< 32) + $signed({33'b0, pl_r}) + 89'sd32768;
    p_ovf   = (full[88:79] != {10{full[79]}});
    p_nxt   = p_ovf ? (full[88] ? SMIN : SMAX) : full[79:16];
    sum     = {p_r[63], p_r} + {cs_r[63], cs_r};
    add_ovf = (sum[64] != sum[63]);
    acc_nxt = ctl.first ? cs_r : (add_ovf ? (sum[64] ? SMIN : SMAX) : sum[63:0]);
    clip_nxt = clip_r
             | (ctl.sc  & ctl.active & sc_ovf)
             | (ctl.rnd & ctl.active & ~ctl.first & p_ovf)
             | (ctl.add & ctl.active & ~ctl.first & add_ovf);
  end

  always_ff @(posedge clk) begin
    if (ctl.sc) begin
      cs_r <= cs_nxt;
      pl_r <= pl_nxt;
    end
    if (ctl.p2) begin
      ph_r <= ph_nxt;
    end
    if (ctl.rnd) begin
      p_r <= p_nxt;
    end
    if (ctl.add && ctl.active) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      clip_r <= 1'b0;
    end else begin
      clip_r <= clip_nxt;
    end
  end

  assign acc_o  = acc_r;
  assign clip_o = clip_r;

endmodule
`default_nettype wire

// ===== design/piecewise_poly_trajectory_eval_top.sv =====
// Top level: request decode, segment search and evaluation sequencer.
// Evaluates a piecewise degree-7 trajectory on three axes. Write transactions
// (tuser 0: segment start, tuser 1: coefficient) are accepted only while no
// query is in flight. A query at or past total_duration goes straight to the
// done state and answers with the end waypoint. Otherwise the query scans
// segment starts from the memory, a read and a compare per start (up to the
// clamped segment count), then reads the 8 coefficients of each axis one at a
// time from the coefficient memory, stepping each through read, scale and low
// partial product, high partial product, round and accumulate, with position,
// velocity and acceleration accumulated in parallel, plus a narrowing step per
// axis. A new transaction is accepted while a finished result waits in the
// output register; the next result waits for it to drain.
`default_nettype none
module piecewise_poly_trajectory_eval_top #(
  parameter int MAX_SEGMENTS = pptev_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: seg_sel[3:0] axis_sel[5:4] power_sel[8:6] write_value[72:9]
  //           query_time[96:73], zero pad to 104 bits
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pptev_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: req_type[1:0]
  input  wire  [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // out_tdata: pos_x[31:0] pos_y[63:32] pos_z[95:64] vel_x[127:96]
  //            vel_y[159:128] vel_z[191:160] acc_x[223:192] acc_y[255:224]
  //            acc_z[287:256] segment_used[291:288] past_end[292]
  //            clipped[293], zero pad to 296 bits
  output logic [pptev_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [2:0]                          cfg_index,
  input  wire  [31:0]                         cfg_data
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CDEPTH = MAX_SEGMENTS * pptev_pkg::NUM_AXES * pptev_pkg::NUM_COEF;
  localparam int AW = $clog2(CDEPTH);
  localparam logic [7:0] MAXS8 = 8'(MAX_SEGMENTS);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SRD  = 10'b00_0000_0010,
    S_SCMP = 10'b00_0000_0100,
    S_CRD  = 10'b00_0000_1000,
    S_SC   = 10'b00_0001_0000,
    S_P2   = 10'b00_0010_0000,
    S_RND  = 10'b00_0100_0000,
    S_ADD  = 10'b00_1000_0000,
    S_NRW  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [4:0]  seg_count_r;
  logic [23:0] total_dur_r;
  logic [31:0] end_r [3];

  // input fields
  logic [1:0]  req;
  logic [3:0]  f_seg;
  logic [1:0]  f_axis;
  logic [2:0]  f_pw;
  logic [63:0] f_wv;
  logic [23:0] f_qt;

  logic in_acc, seg_ok;
  logic [7:0] cnt8, n8;
  logic [IW-1:0] n_last;

  // query context
  logic [23:0]   t_r;
  logic [IW-1:0] seg_idx_r, seg_idx_nxt;
  logic [IW-1:0] seg_k_r, seg_k_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic [2:0]    j_r, j_nxt;
  logic          past_r;
  logic          nclip_r;
  logic [31:0]   pos_res_r [3];
  logic [31:0]   vel_res_r [3];
  logic [31:0]   acc_res_r [3];

  // output register
  logic                                 out_valid_r;
  logic [pptev_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic                                 out_free, out_load;

  // memories
  logic [pptev_pkg::TIME_W-1:0]         start_rdata;
  logic signed [pptev_pkg::COEF_W-1:0]  coef_rdata;
  logic [15:0]                          cw_addr16, cr_addr16;

  // Horner units
  pptev_pkg::horner_ctl_t               ctl_pos, ctl_vel, ctl_acc;
  logic signed [63:0]                   h_pos, h_vel, h_acc;
  logic                                 c_pos, c_vel, c_acc;

  function automatic logic [32:0] narrow(input logic signed [63:0] v);
    logic signed [64:0] s;
    logic [32:0] r;
    s = {v[63], v} + 65'sh8000_0000;
    if (s[64] != s[63]) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, s[63:32]};
    end
    return r;
  endfunction

  logic [32:0] nr_pos, nr_vel, nr_acc;

  assign req    = in_tuser;
  assign f_seg  = in_tdata[3:0];
  assign f_axis = in_tdata[5:4];
  assign f_pw   = in_tdata[8:6];
  assign f_wv   = in_tdata[72:9];
  assign f_qt   = in_tdata[96:73];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign seg_ok    = ({4'b0, f_seg} < MAXS8);
  assign cfg_ready = 1'b1;

  // segment count clamped to 1..MAX_SEGMENTS
  always_comb begin
    cnt8 = {3'b0, seg_count_r};
    if (cnt8 == 8'd0) begin
      n8 = 8'd1;
    end else if (cnt8 > MAXS8) begin
      n8 = MAXS8;
    end else begin
      n8 = cnt8;
    end
    n_last = IW'(n8 - 8'd1);
  end

  assign cw_addr16 = 16'(((16'(f_seg) * 16'd3) + 16'(f_axis)) * 16'd8 + 16'(f_pw));
  assign cr_addr16 = 16'(((16'(seg_k_r) * 16'd3) + 16'(axis_r)) * 16'd8 + 16'(j_r));

  pptev_store #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_store (
    .clk         (clk),
    .start_we    (in_acc && (req == pptev_pkg::REQ_WR_START) && seg_ok),
    .start_waddr (IW'(f_seg)),
    .start_wdata (f_wv[23:0]),
    .start_raddr (seg_idx_r),
    .start_rdata (start_rdata),
    .coef_we     (in_acc && (req == pptev_pkg::REQ_WR_COEF) && seg_ok &&
                  (f_axis != pptev_pkg::AXIS_NONE)),
    .coef_waddr  (cw_addr16[AW-1:0]),
    .coef_wdata  (f_wv),
    .coef_raddr  (cr_addr16[AW-1:0]),
    .coef_rdata  (coef_rdata)
  );

  // one control word per derivative; only the active flag differs
  always_comb begin
    ctl_pos.clr    = in_acc && (req == pptev_pkg::REQ_QUERY);
    ctl_pos.sc     = (state_r == S_SC);
    ctl_pos.p2     = (state_r == S_P2);
    ctl_pos.rnd    = (state_r == S_RND);
    ctl_pos.add    = (state_r == S_ADD);
    ctl_pos.first  = (j_r == 3'd0);
    ctl_pos.active = ({1'b0, j_r} < pptev_pkg::deriv_terms(pptev_pkg::DRV_POS));
    ctl_vel        = ctl_pos;
    ctl_vel.active = ({1'b0, j_r} < pptev_pkg::deriv_terms(pptev_pkg::DRV_VEL));
    ctl_acc        = ctl_pos;
    ctl_acc.active = ({1'b0, j_r} < pptev_pkg::deriv_terms(pptev_pkg::DRV_ACC));
  end

  pptev_horner u_h_pos (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_pos),
    .k(pptev_pkg::deriv_mult(pptev_pkg::DRV_POS, j_r)),
    .coef(coef_rdata), .t(t_r), .acc_o(h_pos), .clip_o(c_pos)
  );

  pptev_horner u_h_vel (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_vel),
    .k(pptev_pkg::deriv_mult(pptev_pkg::DRV_VEL, j_r)),
    .coef(coef_rdata), .t(t_r), .acc_o(h_vel), .clip_o(c_vel)
  );

  pptev_horner u_h_acc (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_acc),
    .k(pptev_pkg::deriv_mult(pptev_pkg::DRV_ACC, j_r)),
    .coef(coef_rdata), .t(t_r), .acc_o(h_acc), .clip_o(c_acc)
  );

  assign nr_pos = narrow(h_pos);
  assign nr_vel = narrow(h_vel);
  assign nr_acc = narrow(h_acc);

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_DONE) && out_free;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    seg_idx_nxt = seg_idx_r;
    seg_k_nxt   = seg_k_r;
    axis_nxt    = axis_r;
    j_nxt       = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (req == pptev_pkg::REQ_QUERY)) begin
          seg_idx_nxt = '0;
          axis_nxt    = 2'd0;
          j_nxt       = 3'd0;
          if (f_qt >= total_dur_r) begin
            seg_k_nxt = n_last;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (start_rdata <= t_r) begin
          if (seg_idx_r != n_last) begin
            seg_idx_nxt = seg_idx_r + 1'b1;
            state_nxt   = S_SRD;
          end else begin
            seg_k_nxt = seg_idx_r;
            state_nxt = S_CRD;
          end
        end else begin
          seg_k_nxt = (seg_idx_r == '0) ? '0 : seg_idx_r - 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_CRD: state_nxt = S_SC;
      S_SC:  state_nxt = S_P2;
      S_P2:  state_nxt = S_RND;
      S_RND: state_nxt = S_ADD;
      S_ADD: begin
        if (j_r == 3'd7) begin
          state_nxt = S_NRW;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = S_CRD;
        end
      end
      S_NRW: begin
        j_nxt = 3'd0;
        if (axis_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_CRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_count_r <= 5'd1;
      total_dur_r <= '0;
      end_r[0]    <= '0;
      end_r[1]    <= '0;
      end_r[2]    <= '0;
      out_valid_r <= 1'b0;
      nclip_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pptev_pkg::REG_SEG_COUNT: seg_count_r <= cfg_data[4:0];
          pptev_pkg::REG_TOTAL_DUR: total_dur_r <= cfg_data[23:0];
          pptev_pkg::REG_END_X:     end_r[0]    <= cfg_data;
          pptev_pkg::REG_END_Y:     end_r[1]    <= cfg_data;
          pptev_pkg::REG_END_Z:     end_r[2]    <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && (req == pptev_pkg::REQ_QUERY)) begin
        nclip_r <= 1'b0;
      end else if (state_r == S_NRW) begin
        nclip_r <= nclip_r | nr_pos[32] | nr_vel[32] | nr_acc[32];
      end
    end
  end

  // query payload
  always_ff @(posedge clk) begin
    seg_idx_r <= seg_idx_nxt;
    seg_k_r   <= seg_k_nxt;
    axis_r    <= axis_nxt;
    j_r       <= j_nxt;
    if (in_acc && (req == pptev_pkg::REQ_QUERY)) begin
      t_r    <= f_qt;
      past_r <= (f_qt >= total_dur_r);
      for (int a = 0; a < 3; a++) begin
        pos_res_r[a] <= end_r[a];
        vel_res_r[a] <= '0;
        acc_res_r[a] <= '0;
      end
    end else if (state_r == S_NRW) begin
      pos_res_r[axis_r] <= nr_pos[31:0];
      vel_res_r[axis_r] <= nr_vel[31:0];
      acc_res_r[axis_r] <= nr_acc[31:0];
    end
    if (out_load) begin
      out_data_r <= {2'b00,
                     nclip_r | c_pos | c_vel | c_acc,
                     past_r,
                     4'(seg_k_r),
                     acc_res_r[2], acc_res_r[1], acc_res_r[0],
                     vel_res_r[2], vel_res_r[1], vel_res_r[0],
                     pos_res_r[2], pos_res_r[1], pos_res_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a query holds off the input side until its result is loaded
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req == pptev_pkg::REQ_QUERY)) |=> !in_tready)
    else $error("input accepted while query in flight");

  // past-end answers never carry a clip
  a_past_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[292]) |-> !out_tdata[293])
    else $error("past-end result flagged as clipped");

  // finishing a query raises valid and frees the input side
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> (out_tvalid && in_tready))
    else $error("finished query not presented");

  // segment scan stays inside the segments in use
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> (seg_idx_r <= n_last))
    else $error("segment scan beyond last segment");

endmodule
`default_nettype wire
